// File: hw/rtl/sdw_pkg.sv
// Shared types and constants for the square/disk warp address core.
// No dependencies; used by sdw_div, sdw_isqrt and the top level.
package sdw_pkg;

  localparam int MAX_SIZE    = 1024;
  localparam int DIV_STEPS   = 17;
  localparam int SQRT_STEPS  = 18;
  localparam int PIPE_LAT    = DIV_STEPS + SQRT_STEPS + 6;
  // 2*sqrt(2) in Q16
  localparam int SQRT2X2_Q16 = 185364;

  typedef enum logic {
    CFG_IMAGE_SIZE = 1'b0,
    CFG_DIRECTION  = 1'b1
  } cfg_idx_t;

  typedef logic signed [16:0] norm_t;   // 2.16 normalized coordinate
  typedef logic [35:0]        rad_t;    // root argument, Q32
  typedef logic [17:0]        root_t;   // floor square root, Q16

endpackage

// File: hw/rtl/sdw_div.sv
// Pipelined restoring divider: idx * 2^17 / size, one quotient bit per stage.
// Gives the normalized coordinate in 2.16. Depends on sdw_pkg.
module sdw_div (
  input  logic          clk,
  input  logic          en,
  input  logic [9:0]    idx,
  input  logic [10:0]   size,
  output sdw_pkg::norm_t norm
);

  logic [9:0]  rem_q [1:sdw_pkg::DIV_STEPS];
  logic [16:0] quo_q [1:sdw_pkg::DIV_STEPS];
  logic        sat_q [1:sdw_pkg::DIV_STEPS];
  logic [17:0] diff;

  for (genvar g = 1; g <= sdw_pkg::DIV_STEPS; g++) begin : g_step
    logic [9:0]  rp;
    logic [16:0] qp;
    logic        sp;
    logic [10:0] r2;
    logic        ge;

    if (g == 1) begin : g_first
      assign rp = idx;
      assign qp = '0;
      assign sp = ({1'b0, idx} >= size);
    end else begin : g_rest
      assign rp = rem_q[g-1];
      assign qp = quo_q[g-1];
      assign sp = sat_q[g-1];
    end

    assign r2 = {rp, 1'b0};
    assign ge = (r2 >= size);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[g] <= ge ? 10'(r2 - size) : r2[9:0];
        quo_q[g] <= {qp[15:0], ge};
        sat_q[g] <= sp;
      end
    end
  end

  assign diff = {1'b0, quo_q[sdw_pkg::DIV_STEPS]} - 18'd65536;
  // saturate coordinates at or beyond the image edge to 1 - 2^-16
  assign norm = sat_q[sdw_pkg::DIV_STEPS] ? 17'sh0FFFF : diff[16:0];

endmodule

// File: hw/rtl/sdw_isqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Floor root of a 36-bit argument. Depends on sdw_pkg.
module sdw_isqrt (
  input  logic           clk,
  input  logic           en,
  input  sdw_pkg::rad_t  rad,
  output sdw_pkg::root_t root
);

  logic [19:0] rem_q  [1:sdw_pkg::SQRT_STEPS];
  logic [17:0] root_q [1:sdw_pkg::SQRT_STEPS];
  logic [35:0] rest_q [1:sdw_pkg::SQRT_STEPS];

  for (genvar g = 1; g <= sdw_pkg::SQRT_STEPS; g++) begin : g_step
    logic [19:0] rp;
    logic [17:0] tp;
    logic [35:0] ap;
    logic [21:0] rsh;
    logic [21:0] trial;
    logic        ge;

    if (g == 1) begin : g_first
      assign rp = '0;
      assign tp = '0;
      assign ap = rad;
    end else begin : g_rest
      assign rp = rem_q[g-1];
      assign tp = root_q[g-1];
      assign ap = rest_q[g-1];
    end

    assign rsh   = {rp, ap[35:34]};
    assign trial = {2'b00, tp, 2'b01};
    assign ge    = (rsh >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[g]  <= ge ? 20'(rsh - trial) : rsh[19:0];
        root_q[g] <= {tp[16:0], ge};
        rest_q[g] <= {ap[33:0], 2'b00};
      end
    end
  end

  assign root = root_q[sdw_pkg::SQRT_STEPS];

endmodule

// File: hw/rtl/square_disk_warp_address_core.sv
// Top level of the square/disk warp address core.
// Depends on sdw_pkg, sdw_div and sdw_isqrt.
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid, in_stall, row, col              | in
//  out     | out_valid, out_stall, mapped_row,         | out
//          |   mapped_col, addr_valid                  |
//  cfg     | cfg_we, cfg_index, cfg_data               | in
//
// One word enters per clock while no output word is held; the datapath is the
// 17-stage coordinate divider and the 18-stage square-root pipeline plus six
// stages of input, products, argument sums, differences, scaling and output.
// The whole pipeline advances together; a stalled output word holds every
// stage, and in_stall rises only while out_valid is high and out_stall is high.
// rst clears the valid chain and loads image_size 512, direction forward.
module square_disk_warp_address_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [9:0]  row,
  input  logic [9:0]  col,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  mapped_row,
  output logic [9:0]  mapped_col,
  output logic        addr_valid
);

  localparam int LAT = sdw_pkg::PIPE_LAT;
  localparam int NS  = sdw_pkg::SQRT_STEPS;

  logic [10:0] image_size;
  logic        direction;
  logic [10:0] sz;
  logic [9:0]  half;
  logic [10:0] size_m1;
  logic        en;

  logic [LAT-1:0] vpipe;
  logic [LAT-1:0] opipe;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= 11'd512;
      direction  <= 1'b0;
    end else if (cfg_we) begin
      case (sdw_pkg::cfg_idx_t'(cfg_index))
        sdw_pkg::CFG_IMAGE_SIZE: image_size <= cfg_data;
        sdw_pkg::CFG_DIRECTION:  direction  <= cfg_data[0];
        default:                 image_size <= image_size;
      endcase
    end
  end

  // clamp size into its legal range
  always_comb begin
    if (image_size < 11'd2) begin
      sz = 11'd2;
    end else if (image_size > 11'(sdw_pkg::MAX_SIZE)) begin
      sz = 11'(sdw_pkg::MAX_SIZE);
    end else begin
      sz = image_size;
    end
  end
  assign half    = sz[10:1];
  assign size_m1 = sz - 11'd1;

  // advance all stages unless the output word is held
  assign en       = !(vpipe[LAT-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], in_valid};
    end
  end

  // stage 0: input word; flag the inverse-mode origin pixel
  logic [9:0] row_0, col_0;
  always_ff @(posedge clk) begin
    if (en) begin
      row_0 <= row;
      col_0 <= col;
      opipe <= {opipe[LAT-2:0], direction && (row == 10'd0) && (col == 10'd0)};
    end
  end

  // stages 1..17: normalize to 2.16
  sdw_pkg::norm_t x_n, y_n;
  sdw_div u_div_x (.clk(clk), .en(en), .idx(row_0), .size(sz), .norm(x_n));
  sdw_div u_div_y (.clk(clk), .en(en), .idx(col_0), .size(sz), .norm(y_n));

  // stage A: squares and the 2*sqrt2 linear terms
  logic signed [33:0] xsq, ysq;
  logic [32:0]        xx_a, yy_a;
  logic signed [35:0] lx_a, ly_a;
  sdw_pkg::norm_t     x_a, y_a;

  assign xsq = 34'(x_n) * 34'(x_n);
  assign ysq = 34'(y_n) * 34'(y_n);

  always_ff @(posedge clk) begin
    if (en) begin
      xx_a <= xsq[32:0];
      yy_a <= ysq[32:0];
      lx_a <= 36'(x_n) * 36'(sdw_pkg::SQRT2X2_Q16);
      ly_a <= 36'(y_n) * 36'(sdw_pkg::SQRT2X2_Q16);
      x_a  <= x_n;
      y_a  <= y_n;
    end
  end

  // stage B: root arguments, negatives clamped to zero
  localparam logic signed [36:0] TWO_Q32 = 37'sh200000000;
  logic signed [36:0] base_r, base_c, a1, a2, a3, a4;
  sdw_pkg::rad_t      fr, fc;
  sdw_pkg::rad_t      rad [4];
  sdw_pkg::norm_t     xd [NS+1];
  sdw_pkg::norm_t     yd [NS+1];

  assign base_r = TWO_Q32 + $signed({4'b0, xx_a}) - $signed({4'b0, yy_a});
  assign base_c = TWO_Q32 + $signed({4'b0, yy_a}) - $signed({4'b0, xx_a});
  assign a1 = base_r + 37'(lx_a);
  assign a2 = base_r - 37'(lx_a);
  assign a3 = base_c + 37'(ly_a);
  assign a4 = base_c - 37'(ly_a);
  assign fr = 36'h100000000 - {4'b0, yy_a[32:1]};
  assign fc = 36'h100000000 - {4'b0, xx_a[32:1]};

  always_ff @(posedge clk) begin
    if (en) begin
      if (!direction) begin
        rad[0] <= fr;
        rad[1] <= '0;
        rad[2] <= fc;
        rad[3] <= '0;
      end else begin
        rad[0] <= a1[36] ? '0 : a1[35:0];
        rad[1] <= a2[36] ? '0 : a2[35:0];
        rad[2] <= a3[36] ? '0 : a3[35:0];
        rad[3] <= a4[36] ? '0 : a4[35:0];
      end
      xd[0] <= x_a;
      yd[0] <= y_a;
      for (int j = 1; j <= NS; j++) begin
        xd[j] <= xd[j-1];
        yd[j] <= yd[j-1];
      end
    end
  end

  // square-root pipelines
  sdw_pkg::root_t s [4];
  for (genvar k = 0; k < 4; k++) begin : g_root
    sdw_isqrt u_isqrt (.clk(clk), .en(en), .rad(rad[k]), .root(s[k]));
  end

  // stage C: warped coordinate plus one, Q32 forward or Q17 inverse
  logic signed [35:0] pr_r, pr_c;
  logic signed [36:0] w_r, w_c;

  assign pr_r = 36'(xd[NS]) * 36'($signed({1'b0, s[0]}));
  assign pr_c = 36'(yd[NS]) * 36'($signed({1'b0, s[2]}));

  always_ff @(posedge clk) begin
    if (en) begin
      if (!direction) begin
        w_r <= 37'(pr_r) + 37'sh100000000;
        w_c <= 37'(pr_c) + 37'sh100000000;
      end else begin
        w_r <= 37'($signed({1'b0, s[0]})) - 37'($signed({1'b0, s[1]})) + 37'sh20000;
        w_c <= 37'($signed({1'b0, s[2]})) - 37'($signed({1'b0, s[3]})) + 37'sh20000;
      end
    end
  end

  // stage D: scale by half the size
  logic [44:0] prod_r, prod_c;
  logic        pos_r, pos_c;
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 45'(w_r[34:0]) * 45'(half);
      prod_c <= 45'(w_c[34:0]) * 45'(half);
      pos_r  <= !w_r[36] && (w_r != '0);
      pos_c  <= !w_c[36] && (w_c != '0);
    end
  end

  // stage E: drop the fraction, saturate, register the output word
  logic [27:0] ar, ac, ar_s, ac_s;
  assign ar = direction ? prod_r[44:17] : {15'b0, prod_r[44:32]};
  assign ac = direction ? prod_c[44:17] : {15'b0, prod_c[44:32]};

  always_comb begin
    ar_s = ar;
    ac_s = ac;
    if (!pos_r) begin
      ar_s = '0;
    end else if (ar > {17'b0, size_m1}) begin
      ar_s = {17'b0, size_m1};
    end
    if (!pos_c) begin
      ac_s = '0;
    end else if (ac > {17'b0, size_m1}) begin
      ac_s = {17'b0, size_m1};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mapped_row <= opipe[LAT-2] ? 10'd0 : ar_s[9:0];
      mapped_col <= opipe[LAT-2] ? 10'd0 : ac_s[9:0];
      addr_valid <= !opipe[LAT-2];
    end
  end

  assign out_valid = vpipe[LAT-1];

endmodule

// File: bench/testbench.sv
// Self-checking bench for square_disk_warp_address_core: random and directed
// pixel coordinates, predicted in fixed point and scored in order.
// Depends on sdw_pkg and the core RTL.

class warp_scoreboard;
  logic [20:0] pending[$];   // {mapped_row, mapped_col, addr_valid}
  int errors;

  function void note_pixel(logic [20:0] exp_word);
    pending.push_back(exp_word);
  endfunction

  function void check_word(logic [9:0] mr, logic [9:0] mc, logic av);
    logic [20:0] e;
    if (pending.size() == 0) begin
      $error("unexpected word row=%0d col=%0d valid=%0d", mr, mc, av);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (e[20:11] !== mr) begin
      $error("mapped_row expected %0d actual %0d", e[20:11], mr);
      errors++;
    end
    if (e[10:1] !== mc) begin
      $error("mapped_col expected %0d actual %0d", e[10:1], mc);
      errors++;
    end
    if (e[0] !== av) begin
      $error("addr_valid expected %0d actual %0d", e[0], av);
      errors++;
    end
  endfunction
endclass

module testbench;

  logic               clk = 0;
  logic               rst = 1;
  logic               cfg_we = 0;
  sdw_pkg::cfg_idx_t  cfg_index = sdw_pkg::CFG_IMAGE_SIZE;
  logic [10:0]        cfg_data = 0;
  logic               in_valid = 0;
  logic               in_stall;
  logic [9:0]         row = 0, col = 0;
  logic               out_valid;
  logic               out_stall = 0;
  logic [9:0]         mapped_row, mapped_col;
  logic               addr_valid;

  // predictor copy of the registers
  logic [10:0] size_reg = 512;
  logic        dir_reg = 0;

  warp_scoreboard sb = new();
  longint cycles = 0;
  localparam longint CYCLE_LIMIT = 400000;

  square_disk_warp_address_core u_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_stall,
    .row, .col, .out_valid, .out_stall, .mapped_row, .mapped_col, .addr_valid
  );

  always #4 clk = ~clk;

  function automatic longint unsigned int_root(longint unsigned a);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > a) bitv >>= 2;
    while (bitv != 0) begin
      if (a >= res + bitv) begin
        a -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Normalize an index to Q16 in [-1, 1 - 2^-16].
  function automatic longint norm_coord(longint idx, longint sz);
    longint v;
    v = (idx * 2 * 65536) / sz - 65536;
    if (v > 65535) v = 65535;
    return v;
  endfunction

  function automatic logic [9:0] scale_addr(longint wp1, int frac, longint sz);
    longint a;
    if (wp1 <= 0) return '0;
    a = (wp1 * (sz >> 1)) >>> frac;
    if (a > sz - 1) a = sz - 1;
    return a[9:0];
  endfunction

  function automatic longint disk_term(longint p, longint q);
    longint arg;
    arg = (64'sd1 <<< 32) - ((q * q) / 2);
    if (arg < 0) arg = 0;
    return p * longint'(int_root(arg));
  endfunction

  function automatic longint square_term(longint p, longint q);
    longint base, lin, a1, a2;
    base = (64'sd2 <<< 32) + p * p - q * q;
    lin = 2 * 92682 * p;
    a1 = base + lin;
    a2 = base - lin;
    if (a1 < 0) a1 = 0;
    if (a2 < 0) a2 = 0;
    return longint'(int_root(a1)) - longint'(int_root(a2));
  endfunction

  function automatic logic [20:0] warp_address(logic [9:0] r, logic [9:0] c);
    longint sz, x, y;
    logic [9:0] mr, mc;
    sz = size_reg;
    if (sz < 2) sz = 2;
    if (sz > sdw_pkg::MAX_SIZE) sz = sdw_pkg::MAX_SIZE;
    x = norm_coord(r, sz);
    y = norm_coord(c, sz);
    if (!dir_reg) begin
      mr = scale_addr(disk_term(x, y) + (64'sd1 <<< 32), 32, sz);
      mc = scale_addr(disk_term(y, x) + (64'sd1 <<< 32), 32, sz);
    end else if (r == 0 && c == 0) begin
      return 21'd0;
    end else begin
      mr = scale_addr(square_term(x, y) + (64'sd1 <<< 17), 17, sz);
      mc = scale_addr(square_term(y, x) + (64'sd1 <<< 17), 17, sz);
    end
    return {mr, mc, 1'b1};
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  // Score output words; stall the output at random, sometimes not at all.
  int stall_mode = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall)
      sb.check_word(mapped_row, mapped_col, addr_valid);
    if (stall_mode == 0) out_stall <= 0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Drive one word and hold it until accepted; valid stays high into the
  // next word when there is no gap.
  task automatic send_pixel(logic [9:0] r, logic [9:0] c, bit allow_gap);
    int g;
    g = allow_gap ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    row <= r;
    col <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pixel(warp_address(r, c));
  endtask

  // Wait for the pipe to drain before touching a register.
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (sdw_pkg::PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic write_reg(sdw_pkg::cfg_idx_t idx, logic [10:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == sdw_pkg::CFG_IMAGE_SIZE) size_reg = val;
    else dir_reg = val[0];
    @(posedge clk);
  endtask

  task automatic random_phase(int n);
    logic [9:0] r, c;
    int lim;
    for (int i = 0; i < n; i++) begin
      lim = (size_reg > 1024) ? 1023 : ((size_reg == 0) ? 3 : size_reg + 2);
      if (lim > 1023) lim = 1023;
      if ($urandom_range(0, 9) == 0) begin
        r = 10'($urandom);
        c = 10'($urandom);
      end else begin
        r = 10'($urandom_range(0, lim));
        c = 10'($urandom_range(0, lim));
      end
      send_pixel(r, c, i % 60 < 40);
    end
  endtask

  logic [10:0] sizes[8] = '{11'd2, 11'd1024, 11'd0, 11'd2047, 11'd3, 11'd640, 11'd1025, 11'd100};

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Reset defaults, then directed extremes in both directions.
    for (int d = 0; d < 2; d++) begin
      if (d == 1) begin
        drain();
        write_reg(sdw_pkg::CFG_DIRECTION, 11'd1);
      end
      send_pixel(10'd0, 10'd0, 1'b0);
      send_pixel(10'd1023, 10'd1023, 1'b0);
      send_pixel(10'd0, 10'd1023, 1'b0);
      send_pixel(10'd1023, 10'd0, 1'b0);
      send_pixel(10'd256, 10'd256, 1'b0);
      send_pixel(10'd511, 10'd0, 1'b0);
      send_pixel(10'h2AA, 10'h155, 1'b0);
      send_pixel(10'h155, 10'h2AA, 1'b0);
    end
    // Sweep sizes and directions, including out-of-range sizes.
    for (int p = 0; p < 16; p++) begin
      drain();
      stall_mode = p % 3;
      write_reg(sdw_pkg::CFG_IMAGE_SIZE, sizes[p % 8]);
      write_reg(sdw_pkg::CFG_DIRECTION, 11'(p[0]));
      if (dir_reg) send_pixel(10'd0, 10'd0, 1'b0);
      random_phase(55);
    end
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (sdw_pkg::PIPE_LAT + 10) @(posedge clk);
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
